// ===== rtl/core/max_tracking_fifo_top_assert.svh =====
// ----------------------------------------------------------------------------
// Max tracking FIFO assertion macros
// Concurrent assertion wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAX_TRACKING_FIFO_TOP_ASSERT_SVH
`define MAX_TRACKING_FIFO_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define MTF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("max tracking fifo: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define MTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("max tracking fifo: next-cycle check failed");

`else

`define MTF_ASSERT_SAME(lbl, ante, cons)
`define MTF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// Max tracking FIFO package
// Depth, operation and status codes, and the types that link the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mtf_pkg;

    // Number of cells in each chain (at least 2).
    localparam int unsigned DEPTH = 64;

    // Operation codes carried by the action field.
    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast to every cell of a chain.
    typedef struct packed {
        logic               push;
        logic               shift;
        logic signed [31:0] value;
    } t_cmd;

    // State of a cell as seen by its neighbors and by the top level.
    typedef struct packed {
        logic               valid;
        logic signed [31:0] value;
    } t_elem_link;

    // Max cell state plus its compare against the pushed word.
    typedef struct packed {
        logic               valid;
        logic               less;
        logic signed [31:0] value;
    } t_max_link;

endpackage

`default_nettype wire

// ===== rtl/core/mtf_elem_cell.sv =====
// ----------------------------------------------------------------------------
// Element cell
// One slot of the shift-register FIFO. A push fills the first empty slot;
// a pop moves every slot one place toward the front.
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_elem_cell
    import mtf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_prev_valid,
    input  wire t_elem_link i_next,
    output t_elem_link      o_link
);

    logic               r_valid;
    logic               n_valid;
    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    // The first empty slot behind a full one takes the pushed word.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_cmd.shift) begin
            n_valid = i_next.valid;
            n_value = i_next.value;
        end else if (i_cmd.push && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_value = i_cmd.value;
        end
    end

    // Valid flag is control state; the word itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.value = r_value;

endmodule

`default_nettype wire

// ===== rtl/core/mtf_max_cell.sv =====
// ----------------------------------------------------------------------------
// Max cell
// One slot of the non-increasing max chain. On a push every slot holding a
// strictly smaller word is dropped and the first such slot (or the first
// empty one) takes the pushed word. A front removal shifts the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module mtf_max_cell
    import mtf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_prev_valid,
    input  wire logic       i_prev_less,
    input  wire t_elem_link i_next,
    output t_max_link       o_link
);

    logic               r_valid;
    logic               n_valid;
    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               less;
    logic               take;

    // Local compare against the pushed word.
    assign less = r_valid && (r_value < i_cmd.value);

    // This slot is the new tail when the slot ahead survives and this one
    // is either empty or dropped.
    assign take = i_prev_valid && !i_prev_less && (!r_valid || less);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_cmd.shift) begin
            n_valid = i_next.valid;
            n_value = i_next.value;
        end else if (i_cmd.push) begin
            if (take) begin
                n_valid = 1'b1;
                n_value = i_cmd.value;
            end else if (less) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.less  = less;
    assign o_link.value = r_value;

endmodule

`default_nettype wire

// ===== rtl/core/max_tracking_fifo_top.sv =====
// ----------------------------------------------------------------------------
// Max tracking FIFO
// FIFO of signed 32-bit words that reports its current maximum after every
// push or pop, built from two rows of cells: the element queue and the
// non-increasing max chain.
//
//   Channel | Handshake                      | Payload
//   --------+--------------------------------+-------------------------------
//   input   | i_in_valid / o_in_stall        | i_action, i_value
//   output  | o_out_valid / i_out_stall      | o_popped_value, o_status,
//           |                                | o_max_value, o_max_valid
//
// For every word all cells of both rows compare and update in
// parallel, and the result lands in the output register on the next edge.
// A new word is accepted each cycle unless the output register is full and
// stalled. Reset is synchronous and empties both rows at once; there is no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module max_tracking_fifo_top
    import mtf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_action,
    input  wire logic signed [31:0] i_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_popped_value,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_max_value,
    output logic                    o_max_valid
);

`include "max_tracking_fifo_top_assert.svh"

    t_elem_link         elem_link [DEPTH];
    t_max_link          max_link  [DEPTH];
    t_cmd               elem_cmd;
    t_cmd               max_cmd;
    logic               accept;
    logic               is_pop;
    logic               push_ok;
    logic               pop_ok;
    logic               max_match;

    logic               r_out_valid;
    logic               n_out_valid;
    logic signed [31:0] r_popped;
    logic signed [31:0] n_popped;
    t_status            r_status;
    t_status            n_status;
    logic signed [31:0] r_max;
    logic signed [31:0] n_max;
    logic               r_max_valid;
    logic               n_max_valid;

    // Handshake: the output register parts the two sides.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_pop     = (t_action'(i_action) == ACT_POP);

    // Decode the word against the front and back of the queue.
    assign push_ok   = accept && !is_pop && !elem_link[DEPTH-1].valid;
    assign pop_ok    = accept && is_pop && elem_link[0].valid;
    assign max_match = max_link[0].valid && (max_link[0].value == elem_link[0].value);

    assign elem_cmd.push  = push_ok;
    assign elem_cmd.shift = pop_ok;
    assign elem_cmd.value = i_value;
    assign max_cmd.push   = push_ok;
    assign max_cmd.shift  = pop_ok && max_match;
    assign max_cmd.value  = i_value;

    // Element row: front at cell 0.
    for (genvar g = 0; g < DEPTH; g++) begin : g_elem
        logic       prev_valid;
        t_elem_link next_link;
        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_rest
            assign prev_valid = elem_link[g-1].valid;
        end
        if (g == DEPTH - 1) begin : g_last
            assign next_link = '0;
        end else begin : g_inner
            assign next_link = elem_link[g+1];
        end
        mtf_elem_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (elem_cmd),
            .i_prev_valid (prev_valid),
            .i_next       (next_link),
            .o_link       (elem_link[g])
        );
    end

    // Max row: current maximum at cell 0.
    for (genvar g = 0; g < DEPTH; g++) begin : g_max
        logic       prev_valid;
        logic       prev_less;
        t_elem_link next_link;
        if (g == 0) begin : g_first
            assign prev_valid = 1'b1;
            assign prev_less  = 1'b0;
        end else begin : g_rest
            assign prev_valid = max_link[g-1].valid;
            assign prev_less  = max_link[g-1].less;
        end
        if (g == DEPTH - 1) begin : g_last
            assign next_link = '0;
        end else begin : g_inner
            assign next_link.valid = max_link[g+1].valid;
            assign next_link.value = max_link[g+1].value;
        end
        mtf_max_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (max_cmd),
            .i_prev_valid (prev_valid),
            .i_prev_less  (prev_less),
            .i_next       (next_link),
            .o_link       (max_link[g])
        );
    end

    // Result word: state as it will stand after this step.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_popped    = r_popped;
        n_status    = r_status;
        n_max       = r_max;
        n_max_valid = r_max_valid;
        if (accept) begin
            n_out_valid = 1'b1;
            n_popped    = '0;
            n_status    = ST_OK;
            n_max       = max_link[0].valid ? max_link[0].value : '0;
            n_max_valid = elem_link[0].valid;
            if (push_ok) begin
                n_max_valid = 1'b1;
                if (!max_link[0].valid || max_link[0].less) begin
                    n_max = i_value;
                end
            end else if (pop_ok) begin
                n_popped    = elem_link[0].value;
                n_max_valid = elem_link[1].valid;
                if (max_match) begin
                    n_max = max_link[1].valid ? max_link[1].value : '0;
                end
            end else if (is_pop) begin
                n_status = ST_EMPTY;
            end else begin
                n_status = ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped    <= n_popped;
        r_status    <= n_status;
        r_max       <= n_max;
        r_max_valid <= n_max_valid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_max_value    = r_max;
    assign o_max_valid    = r_max_valid;

    // The max chain is never longer than the element queue (checked at the front and tail cells).
    `MTF_ASSERT_SAME(a_max_front_needs_elem, max_link[0].valid, elem_link[0].valid)
    `MTF_ASSERT_SAME(a_max_tail_needs_elem, max_link[DEPTH-1].valid, elem_link[DEPTH-1].valid)
    // An accepted pop on an empty queue reports the empty status.
    `MTF_ASSERT_NEXT(a_pop_empty_status, accept && is_pop && !elem_link[0].valid, o_status == ST_EMPTY)
    // An empty queue reports a zero maximum.
    `MTF_ASSERT_SAME(a_empty_max_zero, o_out_valid && !o_max_valid, o_max_value == 32'sd0)

endmodule

`default_nettype wire

// ===== tb/mtf_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// Max tracking FIFO scoreboard
// Tracks the queue contents and the non-increasing peak list as words are
// accepted, and compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
package mtf_scoreboard_pkg;

    import mtf_pkg::*;

    // One predicted result word.
    typedef struct {
        logic signed [31:0] popped_value;
        t_status            status;
        logic signed [31:0] peak_value;
        logic               max_valid;
    } t_fifo_result;

    class max_fifo_scoreboard;
        logic signed [31:0] held_words[$];
        logic signed [31:0] peak_words[$];
        t_fifo_result       expected_results[$];
        int unsigned        error_count;

        function new();
            error_count = 0;
        endfunction

        function int words_held();
            return held_words.size();
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Apply one accepted input word and queue the result it must produce.
        function void note_accepted_word(t_action act, logic signed [31:0] word);
            t_fifo_result r;
            r.popped_value = '0;
            r.status       = ST_OK;
            if (act == ACT_PUSH) begin
                if (held_words.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_words.insert(held_words.size(), word);
                    // Strictly smaller tail entries can never be the maximum again.
                    while (peak_words.size() > 0 && peak_words[$] < word)
                        peak_words.delete(peak_words.size() - 1);
                    if (peak_words.size() < DEPTH)
                        peak_words.insert(peak_words.size(), word);
                end
            end else begin
                if (held_words.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_value = held_words[0];
                    held_words.delete(0);
                    if (peak_words.size() > 0 && peak_words[0] == r.popped_value)
                        peak_words.delete(0);
                end
            end
            r.peak_value = (peak_words.size() > 0) ? peak_words[0] : '0;
            r.max_valid  = (held_words.size() > 0);
            expected_results.insert(expected_results.size(), r);
        endfunction

        // Compare one accepted result word with the oldest prediction.
        function void check_result_word(logic signed [31:0] popped, logic [1:0] status,
                                        logic signed [31:0] peak, logic peak_valid);
            t_fifo_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: result word with none expected: popped %0d status %0d",
                         $time, popped, status);
                error_count++;
                return;
            end
            want = expected_results[0];
            expected_results.delete(0);
            if (popped !== want.popped_value) begin
                $display("%0t: popped_value expected %0d actual %0d",
                         $time, want.popped_value, popped);
                error_count++;
            end
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                error_count++;
            end
            if (peak !== want.peak_value) begin
                $display("%0t: maximum expected %0d actual %0d",
                         $time, want.peak_value, peak);
                error_count++;
            end
            if (peak_valid !== want.max_valid) begin
                $display("%0t: max_valid expected %0d actual %0d",
                         $time, want.max_valid, peak_valid);
                error_count++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Max tracking FIFO testbench
// Drives push and pop words through the valid/stall input channel with
// random idle gaps, stalls the result channel at random, and checks every
// result word against a queue-based prediction of the contents and maximum.
// Covers empty pops, full pushes, extreme values, duplicates and ramps.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mtf_pkg::*;
    import mtf_scoreboard_pkg::*;

    localparam int unsigned RANDOM_WORDS = 600;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_action;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_popped_value;
    logic [1:0]         o_status;
    logic signed [31:0] o_max_value;
    logic               o_max_valid;

    max_fifo_scoreboard sb;
    bit                 quiet;
    int unsigned        random_sent;
    int unsigned        cycle_count = 0;

    max_tracking_fifo_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_max_value    (o_max_value),
        .o_max_valid    (o_max_valid)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check accepted words and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result_word(o_popped_value, o_status, o_max_value, o_max_valid);
        i_out_stall <= !quiet && ($urandom_range(99) < 25);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[max_tracking_fifo_top] ERROR");
            $finish;
        end
    end

    // Present one word and hold it until the block takes it.
    task automatic send_word(input t_action act, input logic signed [31:0] word);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_value    <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_accepted_word(act, word);
        random_sent++;
        // Random idle gap after the word, except in the quiet stretch.
        if (!quiet && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mix of full-range, clustered and extreme values.
    function automatic logic signed [31:0] pick_value();
        int unsigned        sel;
        logic signed [31:0] v;
        sel = $urandom_range(99);
        if (sel < 40) begin
            v = $urandom;
        end else if (sel < 80) begin
            v = $signed($urandom_range(8)) - 4;
        end else begin
            case ($urandom_range(3))
                0:       v = 32'sh7FFF_FFFF;
                1:       v = 32'sh8000_0000;
                2:       v = 32'sh0;
                default: v = -32'sd1;
            endcase
        end
        return v;
    endfunction

    // Stimulus.
    initial begin
        int unsigned        seg;
        int unsigned        k;
        int unsigned        pct;
        int                 step;
        bit                 ramp;
        logic signed [31:0] base;
        logic signed [31:0] v;

        sb          = new();
        quiet       = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_PUSH;
        i_value     <= '0;
        i_out_stall <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty pops, extreme values, duplicate maxima.
        send_word(ACT_POP, 32'sh1234_5678);
        send_word(ACT_PUSH, 32'sh7FFF_FFFF);
        send_word(ACT_PUSH, 32'sh8000_0000);
        send_word(ACT_POP, 32'sh0);
        send_word(ACT_POP, -32'sd1);
        send_word(ACT_POP, 32'sh0);
        send_word(ACT_PUSH, -32'sd1);
        send_word(ACT_PUSH, -32'sd1);
        send_word(ACT_PUSH, 32'sd5);
        send_word(ACT_PUSH, 32'sd5);
        send_word(ACT_PUSH, 32'sd3);
        send_word(ACT_PUSH, 32'sd0);
        send_word(ACT_POP, 32'sh0);
        send_word(ACT_POP, 32'sh0);
        send_word(ACT_POP, 32'sh0);
        send_word(ACT_POP, 32'sh0);
        send_word(ACT_POP, 32'sh0);
        send_word(ACT_PUSH, 32'sh8000_0000);
        send_word(ACT_PUSH, 32'sh8000_0000);
        send_word(ACT_POP, 32'sh0);
        send_word(ACT_POP, 32'sh0);
        send_word(ACT_POP, 32'sh0);
        wait_results();

        // Random part: fills to full, drains to empty, and mixed stretches.
        random_sent = 0;
        seg = 0;
        while (random_sent < RANDOM_WORDS) begin
            quiet <= (seg == 4 || seg == 5);
            case (seg % 4)
                1: begin
                    // Fill to full, often as a ramp that deepens the peak list.
                    ramp = ($urandom_range(1) != 0);
                    base = $urandom;
                    step = $urandom_range(1, 1000);
                    k = 0;
                    while (sb.words_held() < DEPTH) begin
                        v = ramp ? base - $signed(k * step) : pick_value();
                        send_word(ACT_PUSH, v);
                        k++;
                    end
                    repeat ($urandom_range(1, 3)) send_word(ACT_PUSH, pick_value());
                end
                3: begin
                    // Drain to empty, then pop past the end.
                    while (sb.words_held() > 0) send_word(ACT_POP, $urandom);
                    repeat ($urandom_range(1, 2)) send_word(ACT_POP, $urandom);
                    wait_results();
                end
                default: begin
                    pct = (seg % 4 == 0) ? 70 : 35;
                    repeat (50) begin
                        if ($urandom_range(99) < pct)
                            send_word(ACT_PUSH, pick_value());
                        else
                            send_word(ACT_POP, $urandom);
                    end
                end
            endcase
            seg++;
        end

        // Let every result come back, then report the verdict.
        quiet <= 1'b0;
        wait_results();
        repeat (8) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("[max_tracking_fifo_top] OK");
        else
            $display("[max_tracking_fifo_top] ERROR");
        $finish;
    end

endmodule
